FILE: hdl/dise_pkg.sv
// ----------------------------------------------------------------------------
// dise_pkg
// Shared types and constants for the dual integer set engine: opcodes,
// status codes, the command and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package dise_pkg;

  // element width and default store depth
  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  // longest result run of one command
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // opcodes
  localparam logic [3:0] OP_INSERT = 4'd0;
  localparam logic [3:0] OP_REMOVE = 4'd1;
  localparam logic [3:0] OP_MEMBER = 4'd2;
  localparam logic [3:0] OP_SIZE   = 4'd3;
  localparam logic [3:0] OP_SUBSET = 4'd4;
  localparam logic [3:0] OP_EQUAL  = 4'd5;
  localparam logic [3:0] OP_UNION  = 4'd6;
  localparam logic [3:0] OP_INTER  = 4'd7;
  localparam logic [3:0] OP_DIFF   = 4'd8;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SAME = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one command request
  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic              sel;
    logic [3:0]        op;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              value_valid;
    logic              answer;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/dise_set_mem.sv
// ----------------------------------------------------------------------------
// dise_set_mem
// Element store of one set: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dise_set_mem
  import dise_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= store_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/dise_ctrl.sv
// ----------------------------------------------------------------------------
// dise_ctrl
// Command sequencer: walks the set stores through one shared compare and
// index unit, performs updates, and hands result requests to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dise_ctrl
  import dise_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command side
  input  wire logic              start,
  input  wire cmd_t              cmd,
  output logic                   ready,
  // store ports, one read address shared by both stores
  output logic [AW-1:0]          rd_addr,
  input  wire logic [DATA_W-1:0] rd_data_a,
  input  wire logic [DATA_W-1:0] rd_data_b,
  output logic                   we_a,
  output logic                   we_b,
  output logic [AW-1:0]          wr_addr,
  output logic [DATA_W-1:0]      wr_data,
  // result side
  input  wire logic              slot_free,
  output logic                   push_valid,
  output res_t                   push_res
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'h001,
    S_START   = 12'h002,
    S_OFETCH  = 12'h004,
    S_OWAIT   = 12'h008,
    S_IREAD   = 12'h010,
    S_ICMP    = 12'h020,
    S_DECIDE  = 12'h040,
    S_EMIT    = 12'h080,
    S_FINISH  = 12'h100,
    S_SHREAD  = 12'h200,
    S_SHWRITE = 12'h400,
    S_REPLY   = 12'h800
  } state_t;

  state_t                 state_r, state_nxt;
  logic [3:0]             op_r, op_nxt;
  logic                   sel_r, sel_nxt;
  logic [DATA_W-1:0]      key_r, key_nxt;
  logic [CW-1:0]          cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]          cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]          oi_r, oi_nxt;
  logic [CW-1:0]          ii_r, ii_nxt;
  logic                   outer_b_r, outer_b_nxt;
  logic                   inner_b_r, inner_b_nxt;
  logic                   skip_r, skip_nxt;
  logic                   phase2_r, phase2_nxt;
  logic                   found_r, found_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [DATA_W-1:0]      pend_r, pend_nxt;
  logic [RES_CNT_W-1:0]   resn_r, resn_nxt;
  res_t                   reply_r, reply_nxt;

  logic [CW-1:0]          n_left, n_right, n_outer, n_inner;
  logic [DATA_W-1:0]      rd_outer, rd_inner;
  logic                   hit;
  logic [CW-1:0]          ii_inc, oi_inc, ii_dec;
  logic                   we;

  // operand counts and read data selection
  assign n_left   = sel_r     ? cnt_b_r   : cnt_a_r;
  assign n_right  = sel_r     ? cnt_a_r   : cnt_b_r;
  assign n_outer  = outer_b_r ? cnt_b_r   : cnt_a_r;
  assign n_inner  = inner_b_r ? cnt_b_r   : cnt_a_r;
  assign rd_outer = outer_b_r ? rd_data_b : rd_data_a;
  assign rd_inner = inner_b_r ? rd_data_b : rd_data_a;

  // shared compare and index unit
  assign hit    = (rd_inner == key_r);
  assign ii_inc = ii_r + CW'(1);
  assign oi_inc = oi_r + CW'(1);
  assign ii_dec = ii_r - CW'(1);

  // store writes always go to the left set
  assign we_a = we & ~sel_r;
  assign we_b = we & sel_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    sel_nxt     = sel_r;
    key_nxt     = key_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    oi_nxt      = oi_r;
    ii_nxt      = ii_r;
    outer_b_nxt = outer_b_r;
    inner_b_nxt = inner_b_r;
    skip_nxt    = skip_r;
    phase2_nxt  = phase2_r;
    found_nxt   = found_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    resn_nxt    = resn_r;
    reply_nxt   = reply_r;
    ready       = 1'b0;
    rd_addr     = ii_r[AW-1:0];
    we          = 1'b0;
    wr_addr     = n_left[AW-1:0];
    wr_data     = key_r;
    push_valid  = 1'b0;
    push_res    = '0;

    unique case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          op_nxt    = cmd.op;
          sel_nxt   = cmd.sel;
          key_nxt   = cmd.elem;
          state_nxt = S_START;
        end
      end

      // set up the scan for this command
      S_START: begin
        resn_nxt        = '0;
        pend_v_nxt      = 1'b0;
        phase2_nxt      = 1'b0;
        skip_nxt        = 1'b0;
        found_nxt       = 1'b0;
        oi_nxt          = '0;
        ii_nxt          = '0;
        reply_nxt       = '0;
        reply_nxt.last  = 1'b1;
        unique case (op_r)
          OP_INSERT, OP_REMOVE, OP_MEMBER: begin
            inner_b_nxt = sel_r;
            state_nxt   = S_IREAD;
          end
          OP_SIZE: begin
            reply_nxt.value       = DATA_W'(n_left);
            reply_nxt.value_valid = 1'b1;
            state_nxt             = S_REPLY;
          end
          OP_SUBSET, OP_INTER, OP_DIFF: begin
            outer_b_nxt = sel_r;
            inner_b_nxt = ~sel_r;
            state_nxt   = S_OFETCH;
          end
          OP_EQUAL: begin
            if (n_left != n_right) begin
              state_nxt = S_REPLY;
            end else begin
              outer_b_nxt = ~sel_r;
              inner_b_nxt = sel_r;
              state_nxt   = S_OFETCH;
            end
          end
          OP_UNION: begin
            outer_b_nxt = sel_r;
            skip_nxt    = 1'b1;
            state_nxt   = S_OFETCH;
          end
          default: begin
            state_nxt = S_REPLY;
          end
        endcase
      end

      // fetch the next outer element
      S_OFETCH: begin
        rd_addr = oi_r[AW-1:0];
        if (oi_r == n_outer) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_OWAIT;
        end
      end

      S_OWAIT: begin
        key_nxt = rd_outer;
        ii_nxt  = '0;
        if (skip_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IREAD;
        end
      end

      // inner scan for the key
      S_IREAD: begin
        if (ii_r == n_inner) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_ICMP;
        end
      end

      S_ICMP: begin
        if (hit) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          ii_nxt    = ii_inc;
          state_nxt = S_IREAD;
        end
      end

      // act on the scan outcome
      S_DECIDE: begin
        unique case (op_r)
          OP_INSERT: begin
            if (found_r) begin
              reply_nxt.status = ST_SAME;
            end else if (n_left >= CW'(CAPACITY)) begin
              reply_nxt.status = ST_FULL;
            end else begin
              we               = 1'b1;
              reply_nxt.status = ST_DONE;
              if (sel_r) begin
                cnt_b_nxt = n_left + CW'(1);
              end else begin
                cnt_a_nxt = n_left + CW'(1);
              end
            end
            state_nxt = S_REPLY;
          end
          OP_REMOVE: begin
            if (found_r) begin
              ii_nxt    = ii_inc;
              state_nxt = S_SHREAD;
            end else begin
              reply_nxt.status = ST_SAME;
              state_nxt        = S_REPLY;
            end
          end
          OP_MEMBER: begin
            reply_nxt.answer = found_r;
            state_nxt        = S_REPLY;
          end
          OP_SUBSET, OP_EQUAL: begin
            if (found_r) begin
              oi_nxt    = oi_inc;
              state_nxt = S_OFETCH;
            end else begin
              state_nxt = S_REPLY;
            end
          end
          OP_INTER: begin
            if (found_r) begin
              state_nxt = S_EMIT;
            end else begin
              oi_nxt    = oi_inc;
              state_nxt = S_OFETCH;
            end
          end
          OP_DIFF, OP_UNION: begin
            if (found_r) begin
              oi_nxt    = oi_inc;
              state_nxt = S_OFETCH;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_REPLY;
          end
        endcase
      end

      // run element: the held one goes out once the next one is known
      S_EMIT: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            push_valid           = 1'b1;
            push_res.value       = pend_r;
            push_res.value_valid = 1'b1;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = key_r;
          resn_nxt   = resn_r + RES_CNT_W'(1);
          if (resn_r == RES_CNT_W'(MAX_RESULTS - 1)) begin
            reply_nxt.value       = key_r;
            reply_nxt.value_valid = 1'b1;
            reply_nxt.last        = 1'b1;
            state_nxt             = S_REPLY;
          end else begin
            oi_nxt    = oi_inc;
            state_nxt = S_OFETCH;
          end
        end
      end

      // outer loop exhausted
      S_FINISH: begin
        priority if (op_r == OP_SUBSET || op_r == OP_EQUAL) begin
          reply_nxt.answer = 1'b1;
          state_nxt        = S_REPLY;
        end else if (op_r == OP_UNION && !phase2_r) begin
          phase2_nxt  = 1'b1;
          skip_nxt    = 1'b0;
          outer_b_nxt = ~sel_r;
          inner_b_nxt = sel_r;
          oi_nxt      = '0;
          state_nxt   = S_OFETCH;
        end else begin
          if (pend_v_r) begin
            reply_nxt.value       = pend_r;
            reply_nxt.value_valid = 1'b1;
          end
          state_nxt = S_REPLY;
        end
      end

      // close the gap after a removal
      S_SHREAD: begin
        if (ii_r == n_left) begin
          if (sel_r) begin
            cnt_b_nxt = n_left - CW'(1);
          end else begin
            cnt_a_nxt = n_left - CW'(1);
          end
          reply_nxt.status = ST_DONE;
          state_nxt        = S_REPLY;
        end else begin
          state_nxt = S_SHWRITE;
        end
      end

      S_SHWRITE: begin
        we        = 1'b1;
        wr_addr   = ii_dec[AW-1:0];
        wr_data   = rd_inner;
        ii_nxt    = ii_inc;
        state_nxt = S_SHREAD;
      end

      // final result of the command
      S_REPLY: begin
        if (slot_free) begin
          push_valid = 1'b1;
          push_res   = reply_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      pend_v_r <= 1'b0;
      phase2_r <= 1'b0;
      skip_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      pend_v_r <= pend_v_nxt;
      phase2_r <= phase2_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    sel_r     <= sel_nxt;
    key_r     <= key_nxt;
    oi_r      <= oi_nxt;
    ii_r      <= ii_nxt;
    outer_b_r <= outer_b_nxt;
    inner_b_r <= inner_b_nxt;
    found_r   <= found_nxt;
    pend_r    <= pend_nxt;
    resn_r    <= resn_nxt;
    reply_r   <= reply_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/dual_integer_set_engine_core.sv
// ----------------------------------------------------------------------------
// dual_integer_set_engine_core
// Two ordered sets of distinct signed 32-bit integers with insert, remove,
// queries, comparisons and union / intersection / difference runs.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_ stream: in_tuser carries opcode and left set
//   selector, in_tdata the element. Results leave on the out_ stream; every
//   command gives one result, or a run of up to 32 for union, intersection
//   and difference, with out_tlast on its final result.
//   One command is handled at a time; in_tready is high only while idle.
//   The sequencer walks the stores through one compare: insert, member
//   and remove scan the left set (remove then shifts the rest down);
//   subset, equal, intersection and difference scan one set for each
//   element of the other; union emits the left set, then adds a pass
//   over the right set against the left; size and unknown opcodes reply
//   without a scan.
//   Results sit in an output register; when the receiver stalls, the
//   sequencer waits on its next result request and the command lengthens.
//   Reset empties both sets (counts to zero) and drops any pending result;
//   in_tready is high once the sequencer is reset to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_integer_set_engine_core
  import dise_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // element[31:0]
  input  wire logic [4:0]  in_tuser,   // opcode[3:0], left_set[4]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // value[31:0], answer[32], status[34:33]
  output logic             out_tuser,  // value_valid
  output logic             out_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t              cmd;
  logic              accept;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data_a, rd_data_b;
  logic              we_a, we_b;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              slot_free;
  logic              push_valid;
  res_t              push_res;
  logic              out_valid_r;
  res_t              out_res_r;

  // command unpacking
  assign cmd.op   = in_tuser[3:0];
  assign cmd.sel  = in_tuser[4];
  assign cmd.elem = in_tdata;
  assign accept   = in_tvalid & in_tready;

  // set stores
  dise_set_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem_a (
    .clk     (clk),
    .we      (we_a),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data_a)
  );

  dise_set_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem_b (
    .clk     (clk),
    .we      (we_b),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data_b)
  );

  // sequencer
  dise_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .cmd        (cmd),
    .ready      (in_tready),
    .rd_addr    (rd_addr),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .we_a       (we_a),
    .we_b       (we_b),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .slot_free  (slot_free),
    .push_valid (push_valid),
    .push_res   (push_res)
  );

  // output register
  assign slot_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      out_res_r <= push_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.status, out_res_r.answer, out_res_r.value};
  assign out_tuser  = out_res_r.value_valid;
  assign out_tlast  = out_res_r.last;

  // a new command always leaves the sequencer busy
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_tready)
    else $error("sequencer ready right after taking a command");

  // the final result of a command returns the sequencer to idle
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push_valid && push_res.last) |=> in_tready)
    else $error("sequencer not idle after final result");

  // no result request while waiting for a command
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !push_valid)
    else $error("result request while idle");

  // a result request never overwrites an unread result
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && !out_tready) |-> !push_valid)
    else $error("result request overwrote a pending result");

  // a result without a value carries zero
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push_valid && !push_res.value_valid) |-> (push_res.value == '0))
    else $error("nonzero value without value_valid");

endmodule

`default_nettype wire

FILE: tb/dise_checker.sv
// ----------------------------------------------------------------------------
// dise_checker
// Watches the command and result streams of the set engine, keeps its own
// copy of both sets, works out the result requests each command owes and
// compares them field by field as they leave the block.
// ----------------------------------------------------------------------------
module dise_checker
  import dise_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // element[31:0]
  input  logic [4:0]  in_tuser,   // opcode[3:0], left_set[4]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // value[31:0], answer[32], status[34:33]
  input  logic        out_tuser,  // value_valid
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;

  // shadow copy of both sets, index 0 is set A, 1 is set B
  logic [31:0] set_mem [2][CAP];
  int unsigned set_cnt [2];

  // result requests owed by accepted commands, oldest first
  res_t owed_results[$];
  int   err_cnt = 0;

  assign errors = err_cnt;

  function automatic bit set_holds(input int s, input logic [31:0] v);
    for (int i = 0; i < set_cnt[s]; i++)
      if (set_mem[s][i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t make_res(input logic [31:0] value, input logic vv,
                                    input logic ans, input logic [1:0] st,
                                    input logic lst);
    res_t r;
    r.value       = value;
    r.value_valid = vv;
    r.answer      = ans;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  // update the shadow sets and queue the result requests of one command
  task automatic apply_set_command(input logic [3:0] op, input logic sel,
                                   input logic [31:0] elem);
    int          l;
    int          r;
    int unsigned nl;
    int unsigned nr;
    int          j;
    bit          ok;
    res_t        run[$];
    l  = sel ? 1 : 0;
    r  = sel ? 0 : 1;
    nl = set_cnt[l];
    nr = set_cnt[r];
    case (op)
      OP_INSERT: begin
        if (set_holds(l, elem)) begin
          owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_SAME, 1'b1));
        end else if (nl >= CAP) begin
          owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_FULL, 1'b1));
        end else begin
          set_mem[l][nl] = elem;
          set_cnt[l]     = nl + 1;
          owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_DONE, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (set_holds(l, elem)) begin
          // close the gap, keep order
          j = 0;
          for (int i = 0; i < nl; i++) begin
            if (set_mem[l][i] != elem) begin
              set_mem[l][j] = set_mem[l][i];
              j++;
            end
          end
          set_cnt[l] = j;
          owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_DONE, 1'b1));
        end else begin
          owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_SAME, 1'b1));
        end
      end
      OP_MEMBER:
        owed_results.push_back(make_res('0, 1'b0, set_holds(l, elem), ST_DONE, 1'b1));
      OP_SIZE:
        owed_results.push_back(make_res(32'(nl), 1'b1, 1'b0, ST_DONE, 1'b1));
      OP_SUBSET: begin
        ok = 1'b1;
        for (int i = 0; i < nl; i++)
          if (!set_holds(r, set_mem[l][i])) ok = 1'b0;
        owed_results.push_back(make_res('0, 1'b0, ok, ST_DONE, 1'b1));
      end
      OP_EQUAL: begin
        ok = (nl == nr);
        for (int i = 0; i < nr; i++)
          if (!set_holds(l, set_mem[r][i])) ok = 1'b0;
        owed_results.push_back(make_res('0, 1'b0, ok, ST_DONE, 1'b1));
      end
      OP_UNION: begin
        for (int i = 0; i < nl; i++)
          run.push_back(make_res(set_mem[l][i], 1'b1, 1'b0, ST_DONE, 1'b0));
        for (int i = 0; i < nr; i++)
          if (!set_holds(l, set_mem[r][i]))
            run.push_back(make_res(set_mem[r][i], 1'b1, 1'b0, ST_DONE, 1'b0));
      end
      OP_INTER: begin
        for (int i = 0; i < nl; i++)
          if (set_holds(r, set_mem[l][i]))
            run.push_back(make_res(set_mem[l][i], 1'b1, 1'b0, ST_DONE, 1'b0));
      end
      OP_DIFF: begin
        for (int i = 0; i < nl; i++)
          if (!set_holds(r, set_mem[l][i]))
            run.push_back(make_res(set_mem[l][i], 1'b1, 1'b0, ST_DONE, 1'b0));
      end
      default:
        owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_DONE, 1'b1));
    endcase

    // run operations: cut to the longest run, mark the final element
    if (op == OP_UNION || op == OP_INTER || op == OP_DIFF) begin
      while (run.size() > MAX_RESULTS) void'(run.pop_back());
      if (run.size() == 0) begin
        owed_results.push_back(make_res('0, 1'b0, 1'b0, ST_DONE, 1'b1));
      end else begin
        run[run.size()-1].last = 1'b1;
        foreach (run[k]) owed_results.push_back(run[k]);
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, seen);
    err_cnt++;
  endtask

  // compare leaving result requests, then predict newly accepted commands
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      set_cnt[0] = 0;
      set_cnt[1] = 0;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: result request with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          err_cnt++;
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[31:0] !== want.value)
            flag_mismatch("value", want.value, out_tdata[31:0]);
          if (out_tuser !== want.value_valid)
            flag_mismatch("value_valid", 32'(want.value_valid), 32'(out_tuser));
          if (out_tdata[32] !== want.answer)
            flag_mismatch("answer", 32'(want.answer), 32'(out_tdata[32]));
          if (out_tdata[34:33] !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(out_tdata[34:33]));
          if (out_tlast !== want.last)
            flag_mismatch("last", 32'(want.last), 32'(out_tlast));
          if (out_tdata[39:35] !== 5'b0)
            flag_mismatch("tdata padding", 32'(0), 32'(out_tdata[39:35]));
        end
      end
      if (in_tvalid && in_tready)
        apply_set_command(in_tuser[3:0], in_tuser[4], in_tdata);
    end
    pending <= owed_results.size();
  end

  // empty final block; the bench checks what is still owed through pending
  final begin
  end

endmodule

FILE: tb/tb_dual_integer_set_engine_core.sv
// ----------------------------------------------------------------------------
// tb_dual_integer_set_engine_core
// Drives set commands into the engine: a directed opening over empty sets,
// extreme values, every operation and unknown opcodes, then random episodes
// of single commands, mirrored inserts, set fills, set clears and sweeps of
// all comparisons and runs, under several sender idle and receiver stall
// mixes. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_integer_set_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dise_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int errors;
  int pending;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent = 0;
  int cycle_cnt = 0;

  // values inserted per set, so a clear episode can remove them again
  logic [31:0] inserted_vals [2][$];

  dual_integer_set_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dise_checker u_dise_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_insert(input logic sel, input logic [31:0] v);
    int s;
    s = sel ? 1 : 0;
    for (int i = 0; i < inserted_vals[s].size(); i++)
      if (inserted_vals[s][i] == v) return;
    inserted_vals[s].push_back(v);
  endtask

  // send one command request, with random idle cycles ahead of it
  task automatic issue(input logic [3:0] op, input logic sel, input logic [31:0] elem);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sel, op};
    in_tdata  <= elem;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_INSERT) note_insert(sel, elem);
    items_sent++;
  endtask

  // mostly a small pool so sets collide, sometimes extremes or full range
  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 24)) - 32'd12;
    endcase
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_INSERT;
    if (r < 50) return OP_REMOVE;
    if (r < 58) return OP_MEMBER;
    if (r < 62) return OP_SIZE;
    if (r < 68) return OP_SUBSET;
    if (r < 74) return OP_EQUAL;
    if (r < 82) return OP_UNION;
    if (r < 89) return OP_INTER;
    if (r < 96) return OP_DIFF;
    return 4'($urandom_range(9, 15));
  endfunction

  // one random episode of related commands
  task automatic random_episode();
    int          kind;
    logic        sel;
    logic [31:0] v;
    logic [31:0] stride;
    int          s;
    kind = $urandom_range(0, 99);
    sel  = 1'($urandom_range(0, 1));
    s    = sel ? 1 : 0;
    if (kind < 55) begin
      issue(pick_op(), sel, pick_elem());
    end else if (kind < 70) begin
      // same value into both sets, then compare them
      v = pick_elem();
      issue(OP_INSERT, 1'b0, v);
      issue(OP_INSERT, 1'b1, v);
      issue(OP_EQUAL, sel, $urandom);
    end else if (kind < 80) begin
      // fill one set past capacity, then a long union
      v      = $urandom_range(0, 1) ? $urandom : pick_elem();
      stride = 32'($urandom_range(1, 3));
      for (int k = 0; k < CAPACITY_DEF + 2; k++)
        issue(OP_INSERT, sel, v + 32'(k) * stride);
      issue(OP_UNION, 1'($urandom_range(0, 1)), $urandom);
    end else if (kind < 88) begin
      // empty one set again
      for (int i = 0; i < inserted_vals[s].size(); i++)
        issue(OP_REMOVE, sel, inserted_vals[s][i]);
      inserted_vals[s].delete();
      issue(OP_SIZE, sel, $urandom);
    end else begin
      // all comparisons and runs on the current sets
      issue(OP_SUBSET, sel, $urandom);
      issue(OP_EQUAL, sel, $urandom);
      issue(OP_UNION, sel, $urandom);
      issue(OP_INTER, sel, $urandom);
      issue(OP_DIFF, sel, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: empty sets, extremes, every operation
    issue(OP_SIZE,   1'b0, 32'h0000_0000);
    issue(OP_UNION,  1'b0, 32'hffff_ffff);
    issue(OP_SUBSET, 1'b0, 32'h0000_0000);
    issue(OP_EQUAL,  1'b1, 32'h0000_0000);
    issue(OP_MEMBER, 1'b0, 32'h0000_0000);
    issue(OP_REMOVE, 1'b0, 32'h0000_0005);
    issue(OP_INSERT, 1'b0, 32'h8000_0000);
    issue(OP_INSERT, 1'b0, 32'h7fff_ffff);
    issue(OP_INSERT, 1'b0, 32'h8000_0000);
    issue(OP_INSERT, 1'b0, 32'hffff_ffff);
    issue(OP_INSERT, 1'b1, 32'h7fff_ffff);
    issue(OP_INSERT, 1'b1, 32'h0000_0000);
    issue(OP_MEMBER, 1'b0, 32'h7fff_ffff);
    issue(OP_SUBSET, 1'b1, 32'h0000_0000);
    issue(OP_SUBSET, 1'b0, 32'hffff_ffff);
    issue(OP_UNION,  1'b1, 32'h0000_0000);
    issue(OP_INTER,  1'b0, 32'h0000_0000);
    issue(OP_DIFF,   1'b0, 32'h0000_0000);
    issue(OP_REMOVE, 1'b0, 32'h8000_0000);
    issue(OP_SIZE,   1'b0, 32'hffff_ffff);
    issue(OP_EQUAL,  1'b0, 32'h0000_0000);
    issue(4'd9,      1'b1, 32'hffff_ffff);
    issue(4'd15,     1'b0, 32'h5555_aaaa);
    issue(OP_REMOVE, 1'b1, 32'h0000_0000);
    issue(OP_MEMBER, 1'b1, 32'h0000_0000);

    // random part over four idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 60; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 60; end
        default: begin in_idle_pct = 12; out_stall_pct = 12; end
      endcase
      while (items_sent < 25 + PHASE_ITEMS * (p + 1)) random_episode();
    end
    in_tvalid <= 1'b0;

    // drain outstanding result requests
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
